FILE: rtl/gs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs_pkg
// Shared types and constants of the Gauss-Seidel linear solver.
// ----------------------------------------------------------------------------
package gs_pkg;

  localparam int MAX_UNKNOWNS = 16;
  localparam int FRAC_BITS    = 16;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_RHS    = 2'd1,
    OP_START       = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_SIZE_IN_USE       = 2'd0;
  localparam logic [1:0] REG_SWEEP_LIMIT       = 2'd1;
  localparam logic [1:0] REG_TOLERANCE_SQUARED = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [3:0]         sol_index;
    logic signed [31:0] sol_value;
    logic               last_entry;
    logic               converged;
    logic [15:0]        sweeps_done;
    logic               zero_diagonal;
  } out_t;

endpackage

FILE: rtl/gauss_seidel_linear_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_linear_solver
// Fixed-point Gauss-Seidel solver with one shared multiplier and a
// bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Load requests
//   (matrix entry, right-hand entry) give no result.
//   A start request clears the solution and runs sweeps; busy stays high
//   until the last result has been issued.
//   A solve with n unknowns runs sweeps of n row updates. Each row update
//   runs n fetch/multiply/accumulate steps over the single matrix read port
//   and multiplier, then the numerator, the one-bit-per-cycle divider,
//   saturation and the squared change. Results then follow, n of them,
//   each on result for one cycle marked by result_strobe.
//   The receiver cannot stall: results are taken as issued.
//   Configuration writes (cfg_we, cfg_index, cfg_data) act at once; the user
//   makes them only while idle, which the block itself does not enforce.
//   Reset (rst, synchronous) restores the register defaults and goes idle;
//   matrix and right-hand stores stay undefined until written.
// ----------------------------------------------------------------------------
module gauss_seidel_linear_solver (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gs_pkg::in_t    request,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output logic           result_strobe,
  output gs_pkg::out_t   result
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_NUM, S_DIV, S_SAT, S_SQ, S_CHK, S_OUT, S_EMIT
  } state_t;

  localparam int N = gs_pkg::MAX_UNKNOWNS;
  localparam int F = gs_pkg::FRAC_BITS;
  localparam logic signed [63:0] NUM_MAX = (64'sd1 <<< (62 - F)) - 64'sd1;
  localparam logic signed [63:0] NUM_MIN = -(64'sd1 <<< (62 - F));

  state_t state;

  // configuration
  logic [4:0]  size_in_use;
  logic [15:0] sweep_limit;
  logic [31:0] tolerance_squared;

  // sequencer registers
  logic [3:0]         n_m1;
  logic [3:0]         row;
  logic [3:0]         col;
  logic [3:0]         out_idx;
  logic [15:0]        sweep_cnt;
  logic [63:0]        change_acc;
  logic signed [63:0] sum;
  logic signed [31:0] diag;
  logic signed [31:0] x_old;
  logic               q_neg;
  logic [31:0]        dvs;
  logic [62:0]        dvd;
  logic [31:0]        rem;
  logic [5:0]         div_cnt;
  logic               conv;
  logic               zdiag;
  logic signed [67:0] product;

  // stores
  logic [31:0]        mat_mem [N*N];
  logic [31:0]        rhs_mem [N];
  logic signed [31:0] sol [N];
  logic [31:0]        mat_q;
  logic [31:0]        rhs_q;
  logic signed [31:0] sol_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // matrix and right-hand memories, registered read
  always_ff @(posedge clk) begin
    if (accept && request.operation == gs_pkg::OP_LOAD_MATRIX) begin
      mat_mem[{request.row_index, request.col_index}] <= request.entry_value;
    end
    if (accept && request.operation == gs_pkg::OP_LOAD_RHS) begin
      rhs_mem[request.row_index] <= request.entry_value;
    end
    mat_q <= mat_mem[{row, col}];
    rhs_q <= rhs_mem[row];
  end

  // numerator with clamp
  logic signed [63:0] num_raw, num_c;
  logic [63:0]        num_mag;
  always_comb begin
    num_raw = 64'(signed'(rhs_q)) - sum;
    priority if (num_raw > NUM_MAX) num_c = NUM_MAX;
    else if (num_raw < NUM_MIN)     num_c = NUM_MIN;
    else                            num_c = num_raw;
    num_mag = num_c[63] ? 64'(-num_c) : 64'(num_c);
  end

  // divider step
  logic [33:0] trial;
  assign trial = {1'b0, rem, dvd[62]} - {2'b00, dvs};

  // quotient saturation and change
  logic signed [31:0] q_sat;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  always_comb begin
    if (!q_neg) begin
      q_sat = (dvd > 63'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(dvd[31:0]);
    end else begin
      q_sat = (dvd > 63'h8000_0000) ? 32'sh8000_0000 : signed'(32'(-dvd[31:0]));
    end
    diff     = 33'(q_sat) - 33'(x_old);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    if (state == S_SAT) begin
      mul_a = signed'({1'b0, diff_mag});
      mul_b = signed'({1'b0, diff_mag});
    end else begin
      mul_a = 34'(signed'(mat_q));
      mul_b = 34'(sol_q);
    end
  end

  logic signed [63:0] prod_shift;
  assign prod_shift = 64'(product >>> F);

  logic [64:0] acc_sum;
  assign acc_sum = {1'b0, change_acc} + {1'b0, product[63:0]};

  // solution store
  logic [3:0] sol_raddr;
  assign sol_raddr = (state == S_OUT) ? out_idx : col;
  always_ff @(posedge clk) begin
    if (accept && request.operation == gs_pkg::OP_START) begin
      for (int k = 0; k < N; k++) sol[k] <= '0;
    end else if (state == S_SAT) begin
      sol[row] <= q_sat;
    end
    sol_q <= sol[sol_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      size_in_use       <= 5'd16;
      sweep_limit       <= 16'd1000;
      tolerance_squared <= 32'd1;
      result_strobe     <= 1'b0;
      row <= '0; col <= '0; out_idx <= '0; n_m1 <= '0;
      sweep_cnt <= '0; change_acc <= '0; conv <= 1'b0; zdiag <= 1'b0;
      div_cnt <= '0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          gs_pkg::REG_SIZE_IN_USE:       size_in_use <= cfg_data[4:0];
          gs_pkg::REG_SWEEP_LIMIT:       sweep_limit <= cfg_data[15:0];
          gs_pkg::REG_TOLERANCE_SQUARED: tolerance_squared <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && request.operation == gs_pkg::OP_START) begin
            priority if (size_in_use == 5'd0) n_m1 <= 4'd0;
            else if (size_in_use > 5'(N))     n_m1 <= 4'(N - 1);
            else                              n_m1 <= 4'(size_in_use - 5'd1);
            change_acc <= '0;
            conv       <= 1'b0;
            zdiag      <= 1'b0;
            row        <= '0;
            col        <= '0;
            sum        <= '0;
            out_idx    <= '0;
            if (sweep_limit == 16'd0) begin
              sweep_cnt <= '0;
              state     <= S_OUT;
            end else begin
              sweep_cnt <= 16'd1;
              state     <= S_RD;
            end
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          if (col == row) begin
            diag  <= signed'(mat_q);
            x_old <= sol_q;
          end
          product <= mul_a * mul_b;
          state   <= S_ACC;
        end
        S_ACC: begin
          if (col != row) sum <= sum + prod_shift;
          if (col == n_m1) begin
            state <= S_NUM;
          end else begin
            col   <= col + 4'd1;
            state <= S_RD;
          end
        end
        S_NUM: begin
          if (diag == 32'sd0) begin
            zdiag   <= 1'b1;
            out_idx <= '0;
            state   <= S_OUT;
          end else begin
            q_neg   <= num_c[63] ^ diag[31];
            dvs     <= diag[31] ? 32'(-diag) : 32'(diag);
            dvd     <= 63'(num_mag << F);
            rem     <= '0;
            div_cnt <= 6'd62;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!trial[33]) begin
            rem <= trial[31:0];
            dvd <= {dvd[61:0], 1'b1};
          end else begin
            rem <= {rem[30:0], dvd[62]};
            dvd <= {dvd[61:0], 1'b0};
          end
          if (div_cnt == 6'd0) state <= S_SAT;
          else div_cnt <= div_cnt - 6'd1;
        end
        S_SAT: begin
          product <= mul_a * mul_b;
          state   <= S_SQ;
        end
        S_SQ: begin
          change_acc <= acc_sum[64] ? '1 : acc_sum[63:0];
          col <= '0;
          sum <= '0;
          if (row == n_m1) begin
            state <= S_CHK;
          end else begin
            row   <= row + 4'd1;
            state <= S_RD;
          end
        end
        S_CHK: begin
          out_idx <= '0;
          priority if (change_acc < {32'd0, tolerance_squared}) begin
            conv  <= 1'b1;
            state <= S_OUT;
          end else if (sweep_cnt == sweep_limit) begin
            state <= S_OUT;
          end else begin
            sweep_cnt  <= sweep_cnt + 16'd1;
            change_acc <= '0;
            row        <= '0;
            state      <= S_RD;
          end
        end
        S_OUT: state <= S_EMIT;
        S_EMIT: begin
          result_strobe        <= 1'b1;
          result.sol_index     <= out_idx;
          result.sol_value     <= sol_q;
          result.last_entry    <= (out_idx == n_m1);
          result.converged     <= conv;
          result.sweeps_done   <= sweep_cnt;
          result.zero_diagonal <= zdiag;
          if (out_idx == n_m1) begin
            state <= S_IDLE;
          end else begin
            out_idx <= out_idx + 4'd1;
            state   <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !(result.converged && result.zero_diagonal))
    else $error("converged and zero_diagonal both set");

  a_result_cadence: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last_entry |-> ##2 result_strobe)
    else $error("result run broken off");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.operation == gs_pkg::OP_START |=> busy)
    else $error("start request did not raise busy");

endmodule

FILE: bench/tb_gauss_seidel_linear_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gauss_seidel_linear_solver
// Self-checking bench for the fixed-point Gauss-Seidel solver. It fills the
// leading block of both stores, walks a table of directed requests and
// register writes, and then runs random systems (mostly diagonally dominant,
// some noise). A local solver model (the table for typed rows) predicts every
// solution entry; results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_gauss_seidel_linear_solver;

  typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    gs_pkg::in_t        req;
    logic [1:0]         reg_index;
    logic [31:0]        reg_data;
    bit                 typed;
    logic signed [31:0] x_val;
    bit                 conv;
    logic [15:0]        sweeps;
    bit                 zdiag;
  } dir_row_t;

  logic clk, rst, start, busy, cfg_we, result_strobe;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  gs_pkg::in_t  request;
  gs_pkg::out_t result;

  // local copy of block state
  logic signed [31:0] coef[16][16];
  logic signed [31:0] rhs_mem[16];
  logic signed [31:0] xs[16];
  logic [4:0]  size_reg;
  logic [15:0] limit_reg;
  logic [31:0] tol_reg;

  gs_pkg::out_t solution_q[$];
  int   error_count;
  bit   burst_mode;

  gauss_seidel_linear_solver dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Gauss-Seidel solve on the local copy; queues one expected entry per unknown
  function automatic void solve_and_queue(input bit typed, input dir_row_t t);
    longint sum, num, d, q, diff;
    longint lim;
    logic [63:0] mag, sq, acc;
    int n, i, j;
    int unsigned sweeps;
    bit conv, zd;
    gs_pkg::out_t r;
    lim = 64'sd1 <<< (62 - gs_pkg::FRAC_BITS);
    n = (size_reg == 0) ? 1 :
        ((size_reg > gs_pkg::MAX_UNKNOWNS) ? gs_pkg::MAX_UNKNOWNS : size_reg);
    for (i = 0; i < 16; i++) xs[i] = '0;
    sweeps = 0;
    acc = '0;
    conv = 0;
    zd = 0;
    while (sweeps < limit_reg && !conv && !zd) begin
      sweeps++;
      acc = '0;
      for (i = 0; i < n && !zd; i++) begin
        sum = 0;
        for (j = 0; j < n; j++)
          if (j != i)
            sum += (longint'(coef[i][j]) * longint'(xs[j])) >>> gs_pkg::FRAC_BITS;
        d = longint'(coef[i][i]);
        if (d == 0) begin
          zd = 1;
        end else begin
          num = longint'(rhs_mem[i]) - sum;
          if (num > lim - 1) num = lim - 1;
          if (num < -lim) num = -lim;
          q = (num * (64'sd1 <<< gs_pkg::FRAC_BITS)) / d;
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          diff = q - longint'(xs[i]);
          mag = (diff < 0) ? -diff : diff;
          sq = mag * mag;
          if (acc > ~64'd0 - sq) acc = ~64'd0;
          else acc = acc + sq;
          xs[i] = q[31:0];
        end
      end
      if (!zd && acc < {32'd0, tol_reg}) conv = 1;
    end
    for (i = 0; i < n; i++) begin
      r.sol_index     = i[3:0];
      r.sol_value     = typed ? t.x_val : xs[i];
      r.last_entry    = (i == n - 1);
      r.converged     = typed ? t.conv : conv;
      r.sweeps_done   = typed ? t.sweeps : sweeps[15:0];
      r.zero_diagonal = typed ? t.zdiag : zd;
      solution_q.push_back(r);
    end
  endfunction

  // one request: optional gap, then hold start until busy is low at an edge
  task automatic send_request(input gs_pkg::in_t r, input bit typed, input dir_row_t t);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request = r;
    start = 1'b1;
    do @(posedge clk); while (busy);
    case (r.operation)
      gs_pkg::OP_LOAD_MATRIX: coef[r.row_index][r.col_index] = r.entry_value;
      gs_pkg::OP_LOAD_RHS:    rhs_mem[r.row_index] = r.entry_value;
      gs_pkg::OP_START:       solve_and_queue(typed, t);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // register write, only once the block is idle and drained
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    start = 1'b0;
    while (solution_q.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      gs_pkg::REG_SIZE_IN_USE:       size_reg = data[4:0];
      gs_pkg::REG_SWEEP_LIMIT:       limit_reg = data[15:0];
      gs_pkg::REG_TOLERANCE_SQUARED: tol_reg = data;
      default: ;
    endcase
  endtask

  // coefficient values: dominant diagonal, small off-diagonal, or raw noise
  function automatic logic [31:0] pick_value(input bit diag, input bit noise);
    logic [31:0] v;
    if (noise || $urandom_range(0, 9) == 0) begin
      v = $urandom;
      if ($urandom_range(0, 5) == 0) v = '0;
    end else if (diag) begin
      v = $urandom_range(32'h40000, 32'h80000);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = $urandom_range(0, 32'h20000) - 32'h10000;
    end
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    gs_pkg::out_t want;
    if (!rst && result_strobe) begin
      if (solution_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = solution_q.pop_front();
        check_field("sol_index", result.sol_index, want.sol_index);
        check_field("sol_value", result.sol_value, want.sol_value);
        check_field("last_entry", result.last_entry, want.last_entry);
        check_field("converged", result.converged, want.converged);
        check_field("sweeps_done", result.sweeps_done, want.sweeps_done);
        check_field("zero_diagonal", result.zero_diagonal, want.zero_diagonal);
      end
    end
  end

  initial begin
    dir_row_t dir_tbl[$];
    dir_row_t none;
    gs_pkg::in_t r;
    int i, j, k, items, n, loads;
    none = '{ROW_REQUEST, '0, '0, '0, 0, '0, 0, '0, 0};
    error_count = 0;
    burst_mode = 1;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    request = '0;
    size_reg = 5'd16;
    limit_reg = 16'd1000;
    tol_reg = 32'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the leading 4-by-4 block; solves that sweep stay within it
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        r = '{gs_pkg::OP_LOAD_MATRIX, i[3:0], j[3:0], (i == j) ? 32'sh10000 : 32'sh0};
        send_request(r, 0, none);
      end
      r = '{gs_pkg::OP_LOAD_RHS, i[3:0], 4'd0, 32'(i) <<< 16};
      send_request(r, 0, none);
    end

    // directed part
    dir_tbl = '{
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SIZE_IN_USE, 32'd2, 0, '0, 0, '0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SWEEP_LIMIT, 32'd0, 0, '0, 0, '0, 0},
      // no sweep allowed: all zero, not converged
      '{ROW_REQUEST, '{gs_pkg::OP_START, 4'd0, 4'd0, 32'sd0}, '0, '0, 1, 32'sd0, 0,
        16'd0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SWEEP_LIMIT, 32'd65535, 0, '0, 0, '0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_TOLERANCE_SQUARED, 32'hFFFF_FFFF, 0, '0, 0,
        '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_START, 4'd3, 4'd7, 32'sd5}, '0, '0, 0, '0, 0, '0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_TOLERANCE_SQUARED, 32'd1, 0, '0, 0, '0, 0},
      // zero on the first diagonal stops the first sweep at once
      '{ROW_REQUEST, '{gs_pkg::OP_LOAD_MATRIX, 4'd0, 4'd0, 32'sd0}, '0, '0, 0, '0, 0,
        '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_START, 4'd0, 4'd0, 32'sd0}, '0, '0, 1, 32'sd0, 0,
        16'd1, 1},
      '{ROW_REQUEST, '{gs_pkg::OP_LOAD_MATRIX, 4'd0, 4'd0, 32'sh10000}, '0, '0, 0, '0,
        0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_LOAD_MATRIX, 4'd15, 4'd15, 32'sh7FFF_FFFF}, '0, '0,
        0, '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_LOAD_MATRIX, 4'd1, 4'd0, 32'sh8000_0000}, '0, '0,
        0, '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_LOAD_RHS, 4'd1, 4'd15, 32'sh7FFF_FFFF}, '0, '0, 0,
        '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_LOAD_RHS, 4'd14, 4'd0, 32'sh8000_0000}, '0, '0, 0,
        '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_UNUSED, 4'd15, 4'd15, 32'shFFFF_FFFF}, '0, '0, 0,
        '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_START, 4'd0, 4'd0, 32'sd0}, '0, '0, 0, '0, 0, '0, 0},
      // size zero acts as one unknown; zero tolerance never converges
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SIZE_IN_USE, 32'd0, 0, '0, 0, '0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SWEEP_LIMIT, 32'd3, 0, '0, 0, '0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_TOLERANCE_SQUARED, 32'd0, 0, '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_START, 4'd0, 4'd0, 32'sd0}, '0, '0, 0, '0, 0, '0, 0},
      // oversize acts as full size: sixteen zero entries
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SIZE_IN_USE, 32'd31, 0, '0, 0, '0, 0},
      '{ROW_REG_WRITE, '0, gs_pkg::REG_SWEEP_LIMIT, 32'd0, 0, '0, 0, '0, 0},
      '{ROW_REQUEST, '{gs_pkg::OP_START, 4'd0, 4'd0, 32'sd0}, '0, '0, 1, 32'sd0, 0,
        16'd0, 0}
    };
    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].kind == ROW_REG_WRITE)
        write_reg(dir_tbl[k].reg_index, dir_tbl[k].reg_data);
      else
        send_request(dir_tbl[k].req, dir_tbl[k].typed, dir_tbl[k]);
    end

    // random systems: new settings, a batch of loads, then a solve
    items = 0;
    while (items < 64) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(gs_pkg::REG_SIZE_IN_USE, $urandom_range(0, 31));
        n = (size_reg == 0) ? 1 : ((size_reg > 16) ? 16 : size_reg);
        // beyond the filled block only a solve without sweeps is safe
        write_reg(gs_pkg::REG_SWEEP_LIMIT, (n > 4) ? 0 : $urandom_range(0, 40));
      end else begin
        write_reg(gs_pkg::REG_SIZE_IN_USE, $urandom_range(1, 4));
        write_reg(gs_pkg::REG_SWEEP_LIMIT, $urandom_range(1, 40));
      end
      case ($urandom_range(0, 3))
        0:       write_reg(gs_pkg::REG_TOLERANCE_SQUARED, 32'd0);
        1:       write_reg(gs_pkg::REG_TOLERANCE_SQUARED, $urandom);
        default: write_reg(gs_pkg::REG_TOLERANCE_SQUARED, $urandom_range(1, 32'h1000));
      endcase
      n = (size_reg == 0) ? 1 : ((size_reg > 16) ? 16 : size_reg);
      loads = $urandom_range(1, 8);
      for (k = 0; k < loads; k++) begin
        if ($urandom_range(0, 7) == 0) burst_mode = ~burst_mode;
        if ($urandom_range(0, 9) == 0) begin
          // noise anywhere in the stores, an extra solve, or an ignored opcode
          r.operation = 2'($urandom_range(0, 3));
          r.row_index = 4'($urandom);
          r.col_index = 4'($urandom);
          r.entry_value = pick_value(0, 1);
        end else begin
          i = $urandom_range(0, n - 1);
          j = $urandom_range(0, n - 1);
          r.operation = ($urandom_range(0, n) == 0) ? gs_pkg::OP_LOAD_RHS :
                        gs_pkg::OP_LOAD_MATRIX;
          r.row_index = i[3:0];
          r.col_index = j[3:0];
          r.entry_value = (r.operation == gs_pkg::OP_LOAD_RHS) ? pick_value(0, 1) :
                          pick_value(i == j, 0);
        end
        send_request(r, 0, none);
        if (r.operation != gs_pkg::OP_UNUSED) items++;
      end
      r = '{gs_pkg::OP_START, 4'($urandom), 4'($urandom), 32'($urandom)};
      send_request(r, 0, none);
      items++;
    end

    start = 1'b0;
    while (solution_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
